// ----- hw/rtl/qphi_pkg.sv -----
// Package for the quadratic probing hash insert block.
// Holds the sequencer state type and the fixed field and register constants.
// No dependencies.
`timescale 1ns / 1ps

package qphi_pkg;

    // Width of the table size register and of the slot result field.
    localparam int SIZE_W     = 15;
    localparam int SLOT_W     = 14;
    localparam int SIZE_RESET = 16381;

    // Configuration address: one 32-bit register, byte addressed.
    localparam int PADDR_W = 3;
    localparam int REGIX_W = PADDR_W - 2;
    localparam logic [REGIX_W-1:0] REG_TABLE_SIZE = '0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROBE_ADDR,
        ST_PROBE_CHECK,
        ST_PROBE_STEP,
        ST_EMPTY_OUT
    } qphi_state_t;

endpackage

// ----- hw/rtl/quadratic_probe_hash_insert.sv -----
// Top level of the quadratic probing hash insert block.
// Holds the sequencer, the shared modular add unit and the occupancy memory.
// Depends on qphi_pkg.
`timescale 1ns / 1ps

// Inserts keys into an open-addressed table of table_size slots by quadratic
// probing and returns one beat per key: the slot taken, or placed low with
// slot zero when every probe (i = 0 .. table_size inclusive) found its slot
// occupied. Only an occupancy bit per slot is kept, in a one-bit-wide memory
// of TABLE_DEPTH entries. After reset the block sweeps that memory, one entry
// a cycle, with s_ready low until the sweep ends; APB writes are taken during
// the sweep. The block works on one key at a time. A key passes through an
// accept step, a restoring division of the key for the home slot (key mod
// table_size), then for each probe that misses an address step, a memory
// check that also updates the squared offset, and an update of the odd term
// and probe count; the probe that ends the search takes the address step and
// the memory check. The arithmetic of these steps runs through one shared
// modular add/compare/subtract unit, and a new key is accepted only once the
// previous one is through. The result sits in an output register, and a key
// that finishes while the previous result is still unclaimed waits in its
// last step until m_ready frees the register. Sizes above TABLE_DEPTH are
// treated as TABLE_DEPTH; a size of zero places no key and goes from the
// division straight to the result. table_size may only be rewritten while no
// key is in flight; occupancy is kept across such a write.
module quadratic_probe_hash_insert
    import qphi_pkg::*;
#(
    parameter int TABLE_DEPTH = 16384,
    parameter int KEY_BITS    = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KEY_BITS-1:0]  s_key,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SLOT_W-1:0]    m_slot,
    output logic                 m_placed,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Index width into the memory, width of a size value (0 .. TABLE_DEPTH),
    // and a width that holds both a size value and the register contents.
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (SZ_W > SIZE_W) ? SZ_W : SIZE_W;
    localparam int DCNT_W = $clog2(KEY_BITS + 1);

    qphi_state_t state_reg, state_next;

    logic [SIZE_W-1:0]   tbl_size_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic                m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic                m_placed_reg, m_placed_next;

    // Per-key working registers.
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [SZ_W-1:0]     m_reg, m_next;        // active size for this key
    logic [SZ_W-1:0]     home_reg, home_next;  // remainder, then home slot
    logic [SZ_W-1:0]     sq_reg, sq_next;      // i*i mod m
    logic [SZ_W-1:0]     odd_reg, odd_next;    // (2i+1) mod m
    logic [SZ_W-1:0]     two_reg, two_next;    // 2 mod m
    logic [SZ_W-1:0]     probe_reg, probe_next;
    logic [SZ_W-1:0]     addr_reg, addr_next;

    // Occupancy memory with registered read data.
    logic                occ_mem [TABLE_DEPTH];
    logic                occ_rd_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic                mem_wdata;
    logic                mem_re;

    // Shared modular add unit: (a + b) reduced once by m.
    logic [SZ_W:0]       op_a;
    logic [SZ_W-1:0]     op_b;
    logic [SZ_W+1:0]     unit_sum;
    logic [SZ_W+1:0]     unit_diff;
    logic [SZ_W-1:0]     unit_res;

    logic [CMP_W-1:0]    size_ext;
    logic [CMP_W-1:0]    depth_ext;
    logic [CMP_W-1:0]    m_cfg;
    logic [CMP_W-1:0]    addr_ext;
    logic                cfg_wr;
    logic                out_free;
    logic                slot_empty;
    logic                last_probe;

    // ---------------------------------------------------------------------
    // Configuration port. The word index is the byte address without its
    // two low bits.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_TABLE_SIZE);

    always_comb begin
        if (paddr[PADDR_W-1:2] == REG_TABLE_SIZE) begin
            prdata = 32'(tbl_size_reg);
        end else begin
            prdata = '0;
        end
    end

    // Active size: the register value saturated at the memory depth.
    assign size_ext  = CMP_W'(tbl_size_reg);
    assign depth_ext = CMP_W'(TABLE_DEPTH);
    assign m_cfg     = (size_ext > depth_ext) ? depth_ext : size_ext;

    // ---------------------------------------------------------------------
    // Shared unit. The sum of the operands stays below twice m in every use,
    // so one conditional subtract gives the residue.
    // ---------------------------------------------------------------------
    assign unit_sum  = (SZ_W+2)'(op_a) + (SZ_W+2)'(op_b);
    assign unit_diff = unit_sum - (SZ_W+2)'(m_reg);
    assign unit_res  = (unit_sum >= (SZ_W+2)'(m_reg)) ? unit_diff[SZ_W-1:0]
                                                      : unit_sum[SZ_W-1:0];

    assign out_free   = !m_valid_reg || m_ready;
    assign slot_empty = !occ_rd_reg;
    assign last_probe = (probe_reg == m_reg);
    assign addr_ext   = CMP_W'(addr_reg);

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == DCNT_W'(1)) begin
                    if (m_reg == '0) begin
                        state_next = ST_EMPTY_OUT;
                    end else begin
                        state_next = ST_PROBE_ADDR;
                    end
                end
            end
            ST_PROBE_ADDR: begin
                state_next = ST_PROBE_CHECK;
            end
            ST_PROBE_CHECK: begin
                if (slot_empty || last_probe) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_PROBE_STEP;
                end
            end
            ST_PROBE_STEP: begin
                state_next = ST_PROBE_ADDR;
            end
            ST_EMPTY_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: datapath control and outputs.
    // ---------------------------------------------------------------------
    always_comb begin
        s_ready       = 1'b0;
        op_a          = '0;
        op_b          = '0;
        key_next      = key_reg;
        div_cnt_next  = div_cnt_reg;
        m_next        = m_reg;
        home_next     = home_reg;
        sq_next       = sq_reg;
        odd_next      = odd_reg;
        two_next      = two_reg;
        probe_next    = probe_reg;
        addr_next     = addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg[IDX_W-1:0];
        mem_wdata     = 1'b1;
        mem_re        = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_slot_next   = m_slot_reg;
        m_placed_next = m_placed_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 1'b0;
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                key_next     = s_key;
                div_cnt_next = DCNT_W'(KEY_BITS);
                m_next       = m_cfg[SZ_W-1:0];
                home_next    = '0;
                sq_next      = '0;
                probe_next   = '0;
                // Residues of 1 and 2 for the odd-number recurrence.
                odd_next     = (m_cfg > CMP_W'(1)) ? SZ_W'(1) : '0;
                two_next     = (m_cfg > CMP_W'(2)) ? SZ_W'(2) : '0;
            end
            ST_DIV: begin
                // One restoring division step: shift in the next key bit.
                op_a         = {home_reg, key_reg[KEY_BITS-1]};
                home_next    = unit_res;
                key_next     = key_reg << 1;
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
            end
            ST_PROBE_ADDR: begin
                op_a      = {1'b0, home_reg};
                op_b      = sq_reg;
                addr_next = unit_res;
                mem_re    = 1'b1;
            end
            ST_PROBE_CHECK: begin
                if (slot_empty || last_probe) begin
                    if (out_free) begin
                        mem_we        = slot_empty;
                        m_valid_next  = 1'b1;
                        m_placed_next = slot_empty;
                        m_slot_next   = slot_empty ? addr_ext[SLOT_W-1:0] : '0;
                    end
                end else begin
                    // (i+1)^2 = i^2 + (2i+1)
                    op_a    = {1'b0, sq_reg};
                    op_b    = odd_reg;
                    sq_next = unit_res;
                end
            end
            ST_PROBE_STEP: begin
                op_a       = {1'b0, odd_reg};
                op_b       = two_reg;
                odd_next   = unit_res;
                probe_next = probe_reg + SZ_W'(1);
            end
            ST_EMPTY_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_placed_next = 1'b0;
                    m_slot_next   = '0;
                end
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_placed = m_placed_reg;

    // ---------------------------------------------------------------------
    // Registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            tbl_size_reg <= SIZE_W'(SIZE_RESET);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cfg_wr) begin
                tbl_size_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        div_cnt_reg  <= div_cnt_next;
        m_reg        <= m_next;
        home_reg     <= home_next;
        sq_reg       <= sq_next;
        odd_reg      <= odd_next;
        two_reg      <= two_next;
        probe_reg    <= probe_next;
        addr_reg     <= addr_next;
        m_slot_reg   <= m_slot_next;
        m_placed_reg <= m_placed_next;
    end

    // Occupancy memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            occ_rd_reg <= occ_mem[unit_res[IDX_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    // No key is taken while the memory sweep is running.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("key accepted during memory clear");

    // Home slot, squared offset and odd term are proper residues when a probe starts.
    a_residues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE_ADDR) |-> (home_reg < m_reg) && (sq_reg < m_reg)
            && (odd_reg < m_reg))
        else $error("probe operand not reduced");

    // The probed slot always lies inside the active table.
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE_CHECK) |-> (addr_reg < m_reg))
        else $error("probe address beyond active size");

    // The probe counter never runs past the last probe.
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE_STEP) |-> (probe_reg < m_reg))
        else $error("probe count overran");

    // A failed insert reports slot zero.
    a_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_placed_reg) |-> (m_slot_reg == '0))
        else $error("nonzero slot on failed insert");
`endif

endmodule
